@@ hdl/itoc_pkg.sv @@
package itoc_pkg;

  localparam int unsigned CUR_W   = 16;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned DIAL_W  = 11;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned COEFB_W = 31;
  localparam int unsigned COEFA_W = 21;
  localparam int unsigned NSMS_W  = 20;
  localparam int unsigned PROD_W  = DIAL_W + COEFB_W;
  localparam int unsigned NUM_W   = PROD_W + 2 * CUR_W;
  localparam int unsigned SQ_W    = 2 * CUR_W;
  localparam int unsigned AT_W    = DIAL_W + COEFA_W;
  localparam int unsigned T5_W    = MS_W + NSMS_W;
  localparam int unsigned CNT_W   = $clog2(TIME_W);

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [NSMS_W-1:0] NS_PER_MS = NSMS_W'(1000000);

  // configuration register indexes
  localparam logic [1:0] REG_PICKUP = 2'd0;
  localparam logic [1:0] REG_CURVE  = 2'd1;
  localparam logic [1:0] REG_DIAL   = 2'd2;
  localparam logic [1:0] REG_MINMS  = 2'd3;

  // curve codes
  localparam logic [2:0] CURVE_DEFINITE = 3'd5;

  typedef enum logic [2:0] {
    FN_INIT   = 3'd0,
    FN_SAMPLE = 3'd1,
    FN_RESET  = 3'd2,
    FN_TIMER  = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    EV_INIT_DONE  = 2'd0,
    EV_TRIP       = 2'd1,
    EV_START      = 2'd2,
    EV_RESET_DONE = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FAULT  = 2'd1,
    MODE_TRIP   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [CUR_W-1:0] current_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        event_code;
    logic              trip_flag;
    logic [TIME_W-1:0] trip_delay_ns;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic mlo;
    logic mhi;
    logic dinit;
    logic dstep;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic above;
    logic early;
    logic div_last;
  } status_t;

  // curve A term scaled by 1e7
  function automatic logic [COEFA_W-1:0] coef_a(input logic [2:0] sel);
    logic [COEFA_W-1:0] r;
    case (sel)
      3'd0:    r = COEFA_W'(1800000);
      3'd1:    r = COEFA_W'(963000);
      3'd2:    r = COEFA_W'(352000);
      default: r = '0;
    endcase
    return r;
  endfunction

  // curve B term scaled by 1e7
  function automatic logic [COEFB_W-1:0] coef_b(input logic [2:0] sel);
    logic [COEFB_W-1:0] r;
    case (sel)
      3'd0:    r = COEFB_W'(59500000);
      3'd1:    r = COEFB_W'(38800000);
      3'd2:    r = COEFB_W'(56700000);
      3'd3:    r = COEFB_W'(1200000000);
      3'd4:    r = COEFB_W'(500000);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/inverse_time_overcurrent_relay_top.sv @@
// Overcurrent relay sequencer with ANSI inverse-time curves. Events move the
// relay through normal, fault and trip modes and yield at most one result
// each. A sample that enters fault runs the delay computation: squares and
// dial products, a split multiply in low and high halves, then a restoring
// divider retiring one quotient bit per cycle until all 40 bits are done;
// the divider is skipped when the curve or settings give a fixed delay.
// Configuration goes through a plain write port: 0 pickup, 1 curve, 2 dial,
// 3 definite delay in ms.
module inverse_time_overcurrent_relay_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  itoc_pkg::in_item_t  in_data_i,
  output logic                out_valid,
  input  logic                out_ready,
  output itoc_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import itoc_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [TIME_W-1:0] delay;

  itoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (in_data_i.func),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .status_i    (status),
    .delay_i     (delay),
    .cmd_o       (cmd)
  );

  itoc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .current_i  (in_data_i.current_sample),
    .cmd_i      (cmd),
    .status_o   (status),
    .delay_o    (delay)
  );

endmodule

@@ hdl/itoc_datapath.sv @@
module itoc_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [15:0]              cfg_data_i,
  input  logic [itoc_pkg::CUR_W-1:0] current_i,
  input  itoc_pkg::cmd_t           cmd_i,
  output itoc_pkg::status_t        status_o,
  output logic [itoc_pkg::TIME_W-1:0] delay_o
);
  import itoc_pkg::*;

  logic [CUR_W-1:0]  pickup_q;
  logic [2:0]        sel_q;
  logic [DIAL_W-1:0] dial_q;
  logic [MS_W-1:0]   ms_q;

  logic [CUR_W-1:0]  cur_q;
  logic [SQ_W-1:0]   p2_q, c2_q, d_q;
  logic [PROD_W-1:0] m1_q;
  logic [AT_W-1:0]   a_q;
  logic [T5_W-1:0]   t5_q;
  logic [NUM_W-1:0]  n_q;
  logic              early_q;
  logic [TIME_W-1:0] early_val_q;
  logic [SQ_W-1:0]   rem_q;
  logic [TIME_W-1:0] work_q;
  logic              sat_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] delay_q;

  logic [SQ_W:0]     r2;
  logic              ge;
  logic [TIME_W:0]   sum;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pickup_q <= CUR_W'(1000);
      sel_q    <= 3'd0;
      dial_q   <= DIAL_W'(100);
      ms_q     <= MS_W'(10000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PICKUP: pickup_q <= cfg_data_i[CUR_W-1:0];
        REG_CURVE:  sel_q    <= cfg_data_i[2:0];
        REG_DIAL:   dial_q   <= cfg_data_i[DIAL_W-1:0];
        REG_MINMS:  ms_q     <= cfg_data_i[MS_W-1:0];
        default:    sel_q    <= sel_q;
      endcase
    end
  end

  // one restoring division step
  assign r2  = {rem_q, work_q[TIME_W-1]};
  assign ge  = r2 >= {1'b0, d_q};
  assign sum = {1'b0, work_q} + (TIME_W + 1)'(a_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cur_q <= current_i;
    // squares and dial products
    if (cmd_i.sq) begin
      p2_q <= pickup_q * pickup_q;
      c2_q <= cur_q * cur_q;
      m1_q <= PROD_W'(dial_q * coef_b(sel_q));
      a_q  <= AT_W'(dial_q * coef_a(sel_q));
      t5_q <= T5_W'(ms_q * NS_PER_MS);
    end
    // low partial product, divisor and special cases
    if (cmd_i.mlo) begin
      n_q <= NUM_W'(m1_q * p2_q[CUR_W-1:0]);
      d_q <= c2_q - p2_q;
      early_q <= 1'b1;
      if (sel_q == CURVE_DEFINITE) begin
        early_val_q <= TIME_W'(t5_q);
      end else if (sel_q > CURVE_DEFINITE || pickup_q == '0) begin
        early_val_q <= TIME_W'(1);
      end else if (c2_q <= p2_q) begin
        early_val_q <= TIME_MAX;
      end else begin
        early_q     <= 1'b0;
        early_val_q <= '0;
      end
    end
    // high partial product
    if (cmd_i.mhi) begin
      n_q <= n_q + (NUM_W'(m1_q * p2_q[SQ_W-1:CUR_W]) << CUR_W);
    end
    // quotient overflow check and divider load
    if (cmd_i.dinit) begin
      sat_q  <= n_q[NUM_W-1:TIME_W] >= (NUM_W - TIME_W)'(d_q);
      rem_q  <= n_q[TIME_W+SQ_W-1:TIME_W];
      work_q <= n_q[TIME_W-1:0];
      cnt_q  <= '0;
    end
    if (cmd_i.dstep) begin
      rem_q  <= ge ? SQ_W'(r2 - {1'b0, d_q}) : r2[SQ_W-1:0];
      work_q <= {work_q[TIME_W-2:0], ge};
      cnt_q  <= cnt_q + CNT_W'(1);
    end
    // add the constant term and saturate, or take the special-case value
    if (cmd_i.fin) begin
      if (early_q)         delay_q <= early_val_q;
      else if (sat_q)      delay_q <= TIME_MAX;
      else if (sum[TIME_W]) delay_q <= TIME_MAX;
      else                 delay_q <= sum[TIME_W-1:0];
    end
  end

  assign status_o.above    = current_i >= pickup_q;
  assign status_o.early    = early_q;
  assign status_o.div_last = cnt_q == CNT_W'(TIME_W - 1);
  assign delay_o           = delay_q;

endmodule

@@ hdl/itoc_ctrl.sv @@
module itoc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          func_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output itoc_pkg::out_item_t out_data_o,
  input  itoc_pkg::status_t   status_i,
  input  logic [itoc_pkg::TIME_W-1:0] delay_i,
  output itoc_pkg::cmd_t      cmd_o
);
  import itoc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SQ    = 8'b00000010,
    ST_MLO   = 8'b00000100,
    ST_MHI   = 8'b00001000,
    ST_DINIT = 8'b00010000,
    ST_DIV   = 8'b00100000,
    ST_FIN   = 8'b01000000,
    ST_PUT   = 8'b10000000
  } state_e;

  state_e    state_q, state_d;
  mode_e     mode_q, mode_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_free, in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // sequence events and the compute steps
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (mode_q)
            MODE_FAULT: begin
              if (func_i == FN_TIMER) begin
                mode_d = MODE_TRIP;
                out_valid_d = 1'b1;
                out_d = '{event_code: EV_TRIP, trip_flag: 1'b1, trip_delay_ns: '0};
              end else if (func_i == FN_SAMPLE && !status_i.above) begin
                mode_d = MODE_NORMAL;
                out_valid_d = 1'b1;
                out_d = '{event_code: EV_RESET_DONE, trip_flag: 1'b0, trip_delay_ns: '0};
              end
            end
            MODE_TRIP: begin
              if (func_i == FN_CLEAR) begin
                mode_d = MODE_NORMAL;
                out_valid_d = 1'b1;
                out_d = '{event_code: EV_RESET_DONE, trip_flag: 1'b0, trip_delay_ns: '0};
              end
            end
            default: begin
              mode_d = MODE_NORMAL;
              if (func_i == FN_INIT) begin
                out_valid_d = 1'b1;
                out_d = '{event_code: EV_INIT_DONE, trip_flag: 1'b0, trip_delay_ns: '0};
              end else if (func_i == FN_SAMPLE && status_i.above) begin
                mode_d     = MODE_FAULT;
                cmd_o.load = 1'b1;
                state_d    = ST_SQ;
              end
            end
          endcase
        end
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.mlo = 1'b1;
        state_d   = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mhi = 1'b1;
        state_d   = status_i.early ? ST_FIN : ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.dinit = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.dstep = 1'b1;
        if (status_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{event_code: EV_START, trip_flag: 1'b0, trip_delay_ns: delay_i};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_NORMAL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  a_compute_in_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (mode_q == MODE_FAULT))
    else $error("delay computed outside fault mode");
  a_put_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT && out_free) |=> (out_valid_q && out_q.event_code == EV_START))
    else $error("computed delay not presented as start timer");

endmodule
